FILE: rtl/core/phlt_pkg.sv
// ----------------------------------------------------------------------------
// phlt_pkg
// Shared types and codes for the peer heartbeat liveness table: command
// codes, liveness states, register indexes and the cell and result records.
// ----------------------------------------------------------------------------
package phlt_pkg;

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_DEREGISTER = 3'd1;
  localparam logic [2:0] CMD_HEARTBEAT  = 3'd2;
  localparam logic [2:0] CMD_TICK       = 3'd3;
  localparam logic [2:0] CMD_ELECT      = 3'd4;

  localparam logic [1:0] ST_ACTIVE  = 2'd0;
  localparam logic [1:0] ST_SUSPECT = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [1:0] CFG_SUSPECT_AFTER = 2'd0;
  localparam logic [1:0] CFG_DEAD_AFTER    = 2'd1;
  localparam logic [1:0] CFG_LOCAL_SLOT    = 2'd2;

  localparam logic [7:0] SUSPECT_AFTER_RST = 8'd3;
  localparam logic [7:0] DEAD_AFTER_RST    = 8'd5;
  localparam logic [7:0] MISSED_MAX        = 8'd255;
  localparam logic [3:0] MAX_REPORTS       = 4'd15;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] missed;
  } peer_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] slot;
    logic [1:0] status;
    logic       changed;
    logic [7:0] missed;
  } res_t;

  typedef struct packed {
    logic  hit;
    peer_t nxt;
    res_t  res;
  } head_t;

endpackage

FILE: rtl/core/peer_heartbeat_liveness_table.sv
// ----------------------------------------------------------------------------
// peer_heartbeat_liveness_table
// Heartbeat failure detector over a ring of PEERS slot cells. Each request
// rotates the ring once past a head update unit; tick changes are reported
// in ascending slot order, elections pick the lowest active slot.
//
//   channel  ports                                   handshake
//   request  in_cmd, in_slot                         start & !busy
//   result   out_ok .. out_last                      out_strobe, one cycle
//   config   cfg_index, cfg_data                     cfg_valid & cfg_ready
//
// Busy holds after a request is taken for one revolution of the cell ring
// past the head unit plus the finish state, and no new request is taken
// until it drops. Tick reports leave during the revolution, each in the
// cycle after the next change is found; the final result, with out_last
// set, is on the ports in the same cycle that busy drops. Reset is
// synchronous and clears the whole ring.
// ----------------------------------------------------------------------------
module peer_heartbeat_liveness_table #(
  parameter int PEERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot,
  output logic        out_strobe,
  output logic        out_ok,
  output logic [3:0]  out_report_slot,
  output logic [1:0]  out_peer_status,
  output logic        out_changed,
  output logic [7:0]  out_missed,
  output logic [3:0]  out_leader,
  output logic [15:0] out_round,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IDXW = $clog2(PEERS);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FINISH} state_t;

  state_t              state_r;
  logic [IDXW-1:0]     cnt_r;
  logic [2:0]          cmd_r;
  logic [3:0]          slot_r;
  logic [7:0]          suspect_r;
  logic [7:0]          dead_r;
  logic [3:0]          local_r;
  logic [3:0]          leader_r;
  logic [15:0]         round_r;
  phlt_pkg::res_t      pend_r;
  logic                pend_vld_r;
  logic [3:0]          nres_r;
  logic                out_strobe_r;
  phlt_pkg::res_t      out_res_r;
  logic [3:0]          out_leader_r;
  logic [15:0]         out_round_r;
  logic                out_last_r;

  logic                sweep;
  logic                single;
  phlt_pkg::head_t     hd;
  phlt_pkg::peer_t     ring_q [PEERS];

  assign sweep  = state_r == S_SWEEP;
  assign single = cmd_r == phlt_pkg::CMD_REGISTER || cmd_r == phlt_pkg::CMD_DEREGISTER ||
                  cmd_r == phlt_pkg::CMD_HEARTBEAT;

  for (genvar i = 0; i < PEERS; i++) begin : g_ring
    if (i == PEERS - 1) begin : g_tail
      phlt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_i (sweep),
        .d_i     (hd.nxt),
        .q_o     (ring_q[i])
      );
    end else begin : g_body
      phlt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_i (sweep),
        .d_i     (ring_q[i+1]),
        .q_o     (ring_q[i])
      );
    end
  end

  phlt_head #(
    .PEERS (PEERS)
  ) u_head (
    .cmd_i     (cmd_r),
    .slot_i    (slot_r),
    .idx_i     (cnt_r),
    .cur_i     (ring_q[0]),
    .suspect_i (suspect_r),
    .dead_i    (dead_r),
    .local_i   (local_r),
    .full_i    (nres_r == phlt_pkg::MAX_REPORTS),
    .taken_i   (pend_vld_r),
    .hd_o      (hd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      cmd_r        <= '0;
      slot_r       <= '0;
      suspect_r    <= phlt_pkg::SUSPECT_AFTER_RST;
      dead_r       <= phlt_pkg::DEAD_AFTER_RST;
      local_r      <= '0;
      leader_r     <= '0;
      round_r      <= '0;
      pend_r       <= '0;
      pend_vld_r   <= 1'b0;
      nres_r       <= '0;
      out_strobe_r <= 1'b0;
      out_res_r    <= '0;
      out_leader_r <= '0;
      out_round_r  <= '0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          phlt_pkg::CFG_SUSPECT_AFTER: suspect_r <= cfg_data;
          phlt_pkg::CFG_DEAD_AFTER:    dead_r    <= cfg_data;
          phlt_pkg::CFG_LOCAL_SLOT:    local_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= in_cmd;
            slot_r     <= in_slot;
            cnt_r      <= '0;
            pend_vld_r <= 1'b0;
            nres_r     <= '0;
            state_r    <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (hd.hit) begin
            if (pend_vld_r) begin
              out_strobe_r <= 1'b1;
              out_res_r    <= pend_r;
              out_leader_r <= leader_r;
              out_round_r  <= round_r;
            end
            pend_r     <= hd.res;
            pend_vld_r <= 1'b1;
            nres_r     <= nres_r + 4'd1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDXW'(PEERS - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_strobe_r <= 1'b1;
          out_last_r   <= 1'b1;
          out_leader_r <= leader_r;
          out_round_r  <= round_r;
          if (pend_vld_r) begin
            out_res_r <= pend_r;
            if (cmd_r == phlt_pkg::CMD_ELECT) begin
              leader_r     <= pend_r.slot;
              round_r      <= round_r + 16'd1;
              out_leader_r <= pend_r.slot;
              out_round_r  <= round_r + 16'd1;
            end
          end else begin
            out_res_r.ok      <= cmd_r == phlt_pkg::CMD_TICK;
            out_res_r.slot    <= single ? slot_r : 4'd0;
            out_res_r.status  <= phlt_pkg::ST_NONE;
            out_res_r.changed <= 1'b0;
            out_res_r.missed  <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_strobe      = out_strobe_r;
  assign out_ok          = out_res_r.ok;
  assign out_report_slot = out_res_r.slot;
  assign out_peer_status = out_res_r.status;
  assign out_changed     = out_res_r.changed;
  assign out_missed      = out_res_r.missed;
  assign out_leader      = out_leader_r;
  assign out_round       = out_round_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/core/phlt_cell.sv
// ----------------------------------------------------------------------------
// phlt_cell
// One slot of the liveness ring: holds a status and missed count and takes
// its neighbor's value on every shift cycle.
// ----------------------------------------------------------------------------
module phlt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_i,
  input  phlt_pkg::peer_t d_i,
  output phlt_pkg::peer_t q_o
);

  phlt_pkg::peer_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r.status <= phlt_pkg::ST_NONE;
      val_r.missed <= '0;
    end else if (shift_i) begin
      val_r <= d_i;
    end
  end

  assign q_o = val_r;

endmodule

FILE: rtl/core/phlt_head.sv
// ----------------------------------------------------------------------------
// phlt_head
// Update unit at the head of the ring: applies the current request to the
// slot passing by and builds the result for that slot.
// ----------------------------------------------------------------------------
module phlt_head #(
  parameter int PEERS = 16
) (
  input  logic [2:0]             cmd_i,
  input  logic [3:0]             slot_i,
  input  logic [$clog2(PEERS)-1:0] idx_i,
  input  phlt_pkg::peer_t        cur_i,
  input  logic [7:0]             suspect_i,
  input  logic [7:0]             dead_i,
  input  logic [3:0]             local_i,
  input  logic                   full_i,
  input  logic                   taken_i,
  output phlt_pkg::head_t        hd_o
);

  logic       present;
  logic       match;
  logic       is_local;
  logic       low_slot;
  logic [7:0] inc;
  logic [1:0] aged;

  assign present  = cur_i.status != phlt_pkg::ST_NONE;
  assign match    = 7'(slot_i) == 7'(idx_i);
  assign is_local = 7'(local_i) == 7'(idx_i);
  assign low_slot = (idx_i >> 4) == '0;
  assign inc      = (cur_i.missed == phlt_pkg::MISSED_MAX) ? cur_i.missed
                                                           : cur_i.missed + 8'd1;
  assign aged     = (inc >= dead_i)    ? phlt_pkg::ST_DEAD :
                    (inc >= suspect_i) ? phlt_pkg::ST_SUSPECT : cur_i.status;

  always_comb begin
    hd_o             = '0;
    hd_o.nxt         = cur_i;
    hd_o.res.slot    = 4'(idx_i);
    hd_o.res.status  = cur_i.status;
    hd_o.res.missed  = cur_i.missed;
    unique case (cmd_i)
      phlt_pkg::CMD_REGISTER: begin
        if (match) begin
          hd_o.hit = 1'b1;
          if (!present) begin
            hd_o.nxt.status = phlt_pkg::ST_ACTIVE;
            hd_o.nxt.missed = '0;
            hd_o.res.ok     = 1'b1;
            hd_o.res.status = phlt_pkg::ST_ACTIVE;
            hd_o.res.missed = '0;
          end
        end
      end
      phlt_pkg::CMD_DEREGISTER: begin
        if (match) begin
          hd_o.hit = 1'b1;
          if (present) begin
            hd_o.nxt.status = phlt_pkg::ST_NONE;
            hd_o.nxt.missed = '0;
            hd_o.res.ok     = 1'b1;
            hd_o.res.status = phlt_pkg::ST_NONE;
            hd_o.res.missed = '0;
          end
        end
      end
      phlt_pkg::CMD_HEARTBEAT: begin
        if (match) begin
          hd_o.hit = 1'b1;
          if (present) begin
            hd_o.nxt.status  = phlt_pkg::ST_ACTIVE;
            hd_o.nxt.missed  = '0;
            hd_o.res.ok      = 1'b1;
            hd_o.res.status  = phlt_pkg::ST_ACTIVE;
            hd_o.res.changed = cur_i.status != phlt_pkg::ST_ACTIVE;
            hd_o.res.missed  = '0;
          end
        end
      end
      phlt_pkg::CMD_TICK: begin
        if (present && !is_local) begin
          hd_o.nxt.missed = inc;
          if (aged != cur_i.status && !full_i) begin
            hd_o.hit         = 1'b1;
            hd_o.nxt.status  = aged;
            hd_o.res.ok      = 1'b1;
            hd_o.res.status  = aged;
            hd_o.res.changed = 1'b1;
            hd_o.res.missed  = inc;
          end
        end
      end
      phlt_pkg::CMD_ELECT: begin
        if (cur_i.status == phlt_pkg::ST_ACTIVE && low_slot && !taken_i) begin
          hd_o.hit    = 1'b1;
          hd_o.res.ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/liveness_scoreboard.sv
// ----------------------------------------------------------------------------
// liveness_scoreboard
// Watches the request, result and register channels of the peer heartbeat
// liveness table. Keeps its own copy of the slot table, thresholds, leader
// and round, predicts the result records of every accepted request, and
// compares each strobed result against the oldest record still due.
// ----------------------------------------------------------------------------
module liveness_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot,
  input  logic        out_strobe,
  input  logic        out_ok,
  input  logic [3:0]  out_report_slot,
  input  logic [1:0]  out_peer_status,
  input  logic        out_changed,
  input  logic [7:0]  out_missed,
  input  logic [3:0]  out_leader,
  input  logic [15:0] out_round,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          reports_due,
  output int          results_seen
);

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic        changed;
    logic [7:0]  missed;
    logic [3:0]  leader;
    logic [15:0] round;
    logic        last;
  } liveness_report_t;

  logic [1:0]  slot_st [16];
  logic [7:0]  peer_missed [16];
  logic [7:0]  suspect_thr;
  logic [7:0]  dead_thr;
  logic [3:0]  local_id;
  logic [3:0]  lead_slot;
  logic [15:0] round_cnt;

  liveness_report_t liveness_reports_due [$];
  liveness_report_t seen;
  liveness_report_t want;

  function automatic liveness_report_t make_report(input logic ok, input logic [3:0] sl,
                                                   input logic [1:0] status,
                                                   input logic changed,
                                                   input logic [7:0] missed);
    liveness_report_t r;
    r.ok      = ok;
    r.slot    = sl;
    r.status  = status;
    r.changed = changed;
    r.missed  = missed;
    r.leader  = lead_slot;
    r.round   = round_cnt;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic predict_liveness(input logic [2:0] cmd, input logic [3:0] sl);
    liveness_report_t batch [16];
    int               n;
    int               win;
    logic             present;
    logic             hb_changed;
    logic [1:0]       nxt;
    n          = 1;
    win        = -1;
    present    = slot_st[sl] != phlt_pkg::ST_NONE;
    hb_changed = present && slot_st[sl] != phlt_pkg::ST_ACTIVE;
    case (cmd)
      phlt_pkg::CMD_REGISTER: begin
        if (!present) begin
          slot_st[sl]     = phlt_pkg::ST_ACTIVE;
          peer_missed[sl] = '0;
        end
        batch[0] = make_report(!present, sl, slot_st[sl], 1'b0, peer_missed[sl]);
      end
      phlt_pkg::CMD_DEREGISTER: begin
        if (present) begin
          slot_st[sl]     = phlt_pkg::ST_NONE;
          peer_missed[sl] = '0;
        end
        batch[0] = make_report(present, sl, slot_st[sl], 1'b0, peer_missed[sl]);
      end
      phlt_pkg::CMD_HEARTBEAT: begin
        if (present) begin
          slot_st[sl]     = phlt_pkg::ST_ACTIVE;
          peer_missed[sl] = '0;
        end
        batch[0] = make_report(present, sl, slot_st[sl], hb_changed, peer_missed[sl]);
      end
      phlt_pkg::CMD_TICK: begin
        n = 0;
        for (int i = 0; i < 16; i++) begin
          if (slot_st[i] != phlt_pkg::ST_NONE && i != int'(local_id)) begin
            if (peer_missed[i] != phlt_pkg::MISSED_MAX) peer_missed[i]++;
            nxt = slot_st[i];
            if (peer_missed[i] >= dead_thr) nxt = phlt_pkg::ST_DEAD;
            else if (peer_missed[i] >= suspect_thr) nxt = phlt_pkg::ST_SUSPECT;
            if (nxt != slot_st[i] && n < int'(phlt_pkg::MAX_REPORTS)) begin
              slot_st[i] = nxt;
              batch[n] = make_report(1'b1, 4'(i), nxt, 1'b1, peer_missed[i]);
              n++;
            end
          end
        end
        if (n == 0) begin
          batch[0] = make_report(1'b1, 4'd0, phlt_pkg::ST_NONE, 1'b0, 8'd0);
          n = 1;
        end
      end
      phlt_pkg::CMD_ELECT: begin
        for (int i = 0; i < 16; i++) begin
          if (win < 0 && slot_st[i] == phlt_pkg::ST_ACTIVE) win = i;
        end
        if (win >= 0) begin
          round_cnt++;
          lead_slot = 4'(win);
          batch[0] = make_report(1'b1, 4'(win), phlt_pkg::ST_ACTIVE, 1'b0, peer_missed[win]);
        end else begin
          batch[0] = make_report(1'b0, 4'd0, phlt_pkg::ST_NONE, 1'b0, 8'd0);
        end
      end
      default: begin
        batch[0] = make_report(1'b0, 4'd0, phlt_pkg::ST_NONE, 1'b0, 8'd0);
      end
    endcase
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      liveness_reports_due.insert(liveness_reports_due.size(), batch[k]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        slot_st[i]     = phlt_pkg::ST_NONE;
        peer_missed[i] = '0;
      end
      suspect_thr = phlt_pkg::SUSPECT_AFTER_RST;
      dead_thr    = phlt_pkg::DEAD_AFTER_RST;
      local_id    = '0;
      lead_slot   = '0;
      round_cnt   = '0;
      liveness_reports_due.delete();
      fail_count   <= 0;
      reports_due  <= 0;
      results_seen <= 0;
    end else begin
      if (out_strobe) begin
        seen = {out_ok, out_report_slot, out_peer_status, out_changed, out_missed,
                out_leader, out_round, out_last};
        results_seen <= results_seen + 1;
        if (liveness_reports_due.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: result with none due: ok=%0d slot=%0d status=%0d changed=%0d",
                   $time, seen.ok, seen.slot, seen.status, seen.changed);
        end else begin
          want = liveness_reports_due.pop_front();
          if (seen !== want) begin
            fail_count <= fail_count + 1;
            $display("%0t: result mismatch", $time);
            $display(
              "  expected ok=%0d slot=%0d status=%0d changed=%0d missed=%0d leader=%0d round=%0d last=%0d",
              want.ok, want.slot, want.status, want.changed, want.missed,
              want.leader, want.round, want.last);
            $display(
              "  actual   ok=%0d slot=%0d status=%0d changed=%0d missed=%0d leader=%0d round=%0d last=%0d",
              seen.ok, seen.slot, seen.status, seen.changed, seen.missed,
              seen.leader, seen.round, seen.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          phlt_pkg::CFG_SUSPECT_AFTER: suspect_thr = cfg_data;
          phlt_pkg::CFG_DEAD_AFTER:    dead_thr    = cfg_data;
          phlt_pkg::CFG_LOCAL_SLOT:    local_id    = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_liveness(in_cmd, in_slot);
      reports_due <= liveness_reports_due.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the peer heartbeat liveness
// table: a directed walk through every command and corner, then random
// request streams under several threshold and local-slot settings,
// and a directed long tick run past high thresholds.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         PEERS      = 16;
  localparam int         SETTLE     = PEERS + 4;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic [2:0]  in_cmd    = '0;
  logic [3:0]  in_slot   = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  logic        busy;
  logic        out_strobe;
  logic        out_ok;
  logic [3:0]  out_report_slot;
  logic [1:0]  out_peer_status;
  logic        out_changed;
  logic [7:0]  out_missed;
  logic [3:0]  out_leader;
  logic [15:0] out_round;
  logic        out_last;
  logic        cfg_ready;

  int fail_count;
  int reports_due;
  int results_seen;
  int sent_by_cmd [8];
  int cfg_writes;
  bit steady;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  peer_heartbeat_liveness_table #(.PEERS(PEERS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_slot(in_slot),
    .out_strobe(out_strobe), .out_ok(out_ok), .out_report_slot(out_report_slot),
    .out_peer_status(out_peer_status), .out_changed(out_changed),
    .out_missed(out_missed), .out_leader(out_leader), .out_round(out_round),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  liveness_scoreboard sb (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_slot(in_slot),
    .out_strobe(out_strobe), .out_ok(out_ok), .out_report_slot(out_report_slot),
    .out_peer_status(out_peer_status), .out_changed(out_changed),
    .out_missed(out_missed), .out_leader(out_leader), .out_round(out_round),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .reports_due(reports_due), .results_seen(results_seen)
  );

  task automatic issue(input logic [2:0] cmd, input logic [3:0] sl);
    if (!steady && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start   <= 1'b1;
    in_cmd  <= cmd;
    in_slot <= sl;
    do @(posedge clk); while (busy);
    sent_by_cmd[cmd]++;
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic configure(input logic [7:0] sus, input logic [7:0] dead,
                           input logic [7:0] loc);
    drain();
    write_reg(phlt_pkg::CFG_SUSPECT_AFTER, sus);
    write_reg(phlt_pkg::CFG_DEAD_AFTER, dead);
    write_reg(phlt_pkg::CFG_LOCAL_SLOT, loc);
  endtask

  task automatic random_burst(input int count);
    int         pick;
    logic [2:0] cmd;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 20)      cmd = phlt_pkg::CMD_REGISTER;
      else if (pick < 30) cmd = phlt_pkg::CMD_DEREGISTER;
      else if (pick < 55) cmd = phlt_pkg::CMD_HEARTBEAT;
      else if (pick < 85) cmd = phlt_pkg::CMD_TICK;
      else if (pick < 94) cmd = phlt_pkg::CMD_ELECT;
      else                cmd = 3'($urandom_range(5, 7));
      issue(cmd, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("peer_heartbeat_liveness_table verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then basic register / refuse paths at default thresholds
    issue(phlt_pkg::CMD_ELECT, 4'd0);
    issue(phlt_pkg::CMD_TICK, 4'd0);
    issue(phlt_pkg::CMD_REGISTER, 4'd0);
    issue(phlt_pkg::CMD_REGISTER, 4'd0);
    issue(phlt_pkg::CMD_REGISTER, 4'd15);
    issue(phlt_pkg::CMD_REGISTER, 4'd5);
    issue(phlt_pkg::CMD_DEREGISTER, 4'd9);
    issue(phlt_pkg::CMD_HEARTBEAT, 4'd3);
    repeat (3) issue(phlt_pkg::CMD_TICK, 4'd7);
    issue(phlt_pkg::CMD_HEARTBEAT, 4'd5);
    repeat (2) issue(phlt_pkg::CMD_TICK, 4'd8);
    issue(phlt_pkg::CMD_ELECT, 4'd0);
    issue(phlt_pkg::CMD_DEREGISTER, 4'd0);
    issue(phlt_pkg::CMD_ELECT, 4'd15);
    for (int c = 5; c < 8; c++) issue(3'(c), 4'(c));
    issue(phlt_pkg::CMD_DEREGISTER, 4'd15);
    issue(phlt_pkg::CMD_HEARTBEAT, 4'd15);

    // dead threshold wins over suspect when both are one
    configure(8'd1, 8'd1, 8'd15);
    random_burst(25);

    // zero suspect threshold, local slot taken from the low bits only
    configure(8'd0, 8'd255, 8'hA7);
    random_burst(25);

    // long tick run past high thresholds
    configure(8'd40, 8'd50, 8'd3);
    write_reg(CFG_UNUSED, 8'h5A);
    issue(phlt_pkg::CMD_REGISTER, 4'd2);
    issue(phlt_pkg::CMD_REGISTER, 4'd3);
    issue(phlt_pkg::CMD_REGISTER, 4'd9);
    repeat (60) issue(phlt_pkg::CMD_TICK, 4'($urandom_range(15)));
    issue(phlt_pkg::CMD_ELECT, 4'd0);
    issue(phlt_pkg::CMD_HEARTBEAT, 4'd9);

    steady = 1'b1;
    configure(8'd2, 8'd4, 8'd0);
    random_burst(40);
    steady = 1'b0;

    repeat (2) begin
      configure(8'($urandom_range(1, 8)), 8'($urandom_range(1, 10)),
                8'($urandom_range(255)));
      random_burst(25);
    end

    drain();
    $display("Run covered %0d register, %0d deregister, %0d heartbeat, %0d tick, %0d elect",
             sent_by_cmd[phlt_pkg::CMD_REGISTER], sent_by_cmd[phlt_pkg::CMD_DEREGISTER],
             sent_by_cmd[phlt_pkg::CMD_HEARTBEAT], sent_by_cmd[phlt_pkg::CMD_TICK],
             sent_by_cmd[phlt_pkg::CMD_ELECT]);
    $display("requests, %0d unknown codes, %0d register writes, %0d results checked",
             sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7], cfg_writes, results_seen);
    if (fail_count == 0 && reports_due == 0) begin
      $display("peer_heartbeat_liveness_table verification clean");
    end else begin
      $display("peer_heartbeat_liveness_table verification failed");
    end
    $finish;
  end

endmodule
